// File: design/gb3_pkg.sv
// Shared types and constants of the 3x3 Gaussian blur block.
// No dependencies; every other file of the block imports this package.
package gb3_pkg;

  // Pixel and result widths
  localparam int PIX_W = 8;
  localparam int KERNEL_SHIFT = 4;
  localparam int SUM_W = PIX_W + KERNEL_SHIFT;

  // Default size limits, handed to the top level as parameter defaults
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 13;
  localparam int FRAME_WIDTH_W = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  // Input item kinds
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // One pixel step as the front hands it to the back. The column travels
  // beside it, since its width follows the size parameters.
  typedef struct packed {
    logic             virt;     // virtual step: bottom row repeats the middle row
    logic             top_mid;  // second row of the frame: top row repeats the middle
    logic             emit;     // this step completes an output pixel
    logic             last;     // that output pixel is the final one of the frame
    logic             clamp_l;  // output column is the left edge
    logic             clamp_r;  // output column is the right edge
    logic [PIX_W-1:0] pix;
  } gb3_op_t;

endpackage

// File: design/gb3_ifs.sv
// Handshake channels of the blur block: pixel input, result output and
// configuration writes. Depends on gb3_pkg.
interface gb3_pix_if import gb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, mode, pixel_in, input ready);
  modport sink (input valid, mode, pixel_in, output ready);
endinterface

interface gb3_res_if import gb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blurred_pixel;
  logic             frame_last;

  modport source (output valid, blurred_pixel, frame_last, input ready);
  modport sink (input valid, blurred_pixel, frame_last, output ready);
endinterface

interface gb3_cfg_if import gb3_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/gb3_front.sv
// Front end of the blur block: holds the frame size and raster position,
// classifies each input item and issues pixel steps. Depends on gb3_pkg, gb3_ifs.
module gb3_front import gb3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  gb3_pix_if.sink                      pixels,
  gb3_cfg_if.sink                      cfg,
  input  logic                         q_not_full,
  output logic                         push,
  output gb3_op_t                      op,
  output logic [$clog2(MAX_WIDTH)-1:0] op_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 2);

  logic [WW-1:0] width;
  logic [HW-1:0] height;
  logic [CW-1:0] col;
  logic [YW-1:0] row;

  logic [WW-1:0] width_sat;
  logic [HW-1:0] height_sat;
  logic          in_done;
  logic          is_push;
  logic          take_step;
  logic          emit;
  logic          last;
  logic          col_end;

  assign cfg.ready = 1'b1;

  always_comb begin
    width_sat = WW'(MAX_WIDTH);
    if (cfg.data[FRAME_WIDTH_W-1:0] == '0) begin
      width_sat = WW'(1);
    end else if (32'(cfg.data[FRAME_WIDTH_W-1:0]) <= 32'(MAX_WIDTH)) begin
      width_sat = WW'(cfg.data[FRAME_WIDTH_W-1:0]);
    end
    height_sat = HW'(MAX_HEIGHT);
    if (cfg.data[FRAME_HEIGHT_W-1:0] == '0) begin
      height_sat = HW'(1);
    end else if (32'(cfg.data[FRAME_HEIGHT_W-1:0]) <= 32'(MAX_HEIGHT)) begin
      height_sat = HW'(cfg.data[FRAME_HEIGHT_W-1:0]);
    end
  end

  // Once the row count reaches the height, every real pixel is in and only
  // flush items move the raster on, through the virtual rows below the frame.
  always_comb begin
    in_done   = row >= YW'(height);
    is_push   = pixels.mode == MODE_PUSH;
    take_step = is_push ? !in_done : in_done;
    emit      = (row >= YW'(2)) || ((row == YW'(1)) && (col != '0));
    last      = (row == YW'(height) + YW'(1)) && (col == '0);
    col_end   = WW'(col) == width - WW'(1);
  end

  // A flush that does not yet complete an output (single-row frames) issues
  // its step but is held, so its next issued step is the one that does.
  assign pixels.ready = q_not_full && !(!is_push && in_done && !emit);
  assign push = pixels.valid && q_not_full && take_step;

  always_comb begin
    op.virt    = !is_push;
    op.top_mid = row == YW'(1);
    op.emit    = emit;
    op.last    = last;
    op.clamp_l = (col == CW'(1)) || ((col == '0) && (width == WW'(1)));
    op.clamp_r = col == '0;
    op.pix     = pixels.pixel_in;
    op_col     = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WW'(1);
      height <= HW'(1);
      col    <= '0;
      row    <= '0;
    end else if (cfg.valid && (cfg.index == REG_FRAME_WIDTH)) begin
      width <= width_sat;
      col   <= '0;
      row   <= '0;
    end else if (cfg.valid && (cfg.index == REG_FRAME_HEIGHT)) begin
      height <= height_sat;
      col    <= '0;
      row    <= '0;
    end else if (push) begin
      if (emit && last) begin
        col <= '0;
        row <= '0;
      end else if (col_end) begin
        col <= '0;
        row <= row + YW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    push && op.last |-> op.emit)
    else $error("final step of a frame issued without an output");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= YW'(height) + YW'(1))
    else $error("raster row ran past the drain rows");

  a_flush_gives_result: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && pixels.ready && (pixels.mode == MODE_FLUSH) && in_done
    |-> push && op.emit)
    else $error("accepted flush item issued no output step");

endmodule

// File: design/gb3_queue.sv
// Short queue of pixel steps between the front and back of the blur block.
// Depends on gb3_pkg.
module gb3_queue import gb3_pkg::*; #(
  parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gb3_op_t          push_op,
  input  logic [COL_W-1:0] push_col,
  output logic             not_full,
  input  logic             pop,
  output gb3_op_t          head_op,
  output logic [COL_W-1:0] head_col,
  output logic             not_empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  gb3_op_t          ops [QUEUE_DEPTH];
  logic [COL_W-1:0] cols [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_pop;

  assign not_full  = count != NW'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign do_pop    = pop && not_empty;
  assign head_op   = ops[rd_ptr];
  assign head_col  = cols[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ops[wr_ptr]  <= push_op;
      cols[wr_ptr] <= push_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> not_full)
    else $error("step pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

// File: design/gb3_back.sv
// Back end of the blur block: line stores, 3x3 tap window, kernel sum and
// the output register. Depends on gb3_pkg, gb3_ifs.
module gb3_back import gb3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_not_empty,
  input  gb3_op_t                      q_op,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  output logic                         pop,
  gb3_res_if.source                    blurred
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = PIX_W + 2;

  logic [PIX_W-1:0] upper_store [MAX_WIDTH];
  logic [PIX_W-1:0] middle_store [MAX_WIDTH];

  // Read stage
  logic             a_valid;
  gb3_op_t          a_op;
  logic [CW-1:0]    a_col;
  logic [PIX_W-1:0] rd_upper;
  logic [PIX_W-1:0] rd_middle;

  // Window stage: win[column][row], column 0 oldest, row 0 top
  logic [PIX_W-1:0] win [3][3];
  logic             b_valid;
  logic             b_last;
  logic             b_cl;
  logic             b_cr;

  // Output register
  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic             out_last;

  logic             adv;
  logic             step;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] bot;
  logic [PIX_W-1:0] lft [3];
  logic [PIX_W-1:0] rgt [3];
  logic [RW-1:0]    row_sum [3];
  logic [SUM_W-1:0] sum;

  // The whole back moves as one pipeline; the queue in front of it absorbs
  // a stall at the output.
  assign adv  = !out_valid || blurred.ready;
  assign pop  = adv && q_not_empty;
  assign step = adv && a_valid;

  assign blurred.valid         = out_valid;
  assign blurred.blurred_pixel = out_pix;
  assign blurred.frame_last    = out_last;

  always_comb begin
    top = a_op.top_mid ? rd_middle : rd_upper;
    bot = a_op.virt ? rd_middle : a_op.pix;
  end

  // Line stores. A step written in the same cycle as a read of its column
  // (one-column frames) is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (step) begin
      upper_store[a_col]  <= rd_middle;
      middle_store[a_col] <= bot;
    end
    if (pop) begin
      if (step && (a_col == q_col)) begin
        rd_upper  <= rd_middle;
        rd_middle <= bot;
      end else begin
        rd_upper  <= upper_store[q_col];
        rd_middle <= middle_store[q_col];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lft[r]     = b_cl ? win[1][r] : win[0][r];
      rgt[r]     = b_cr ? win[1][r] : win[2][r];
      row_sum[r] = RW'(lft[r]) + (RW'(win[1][r]) << 1) + RW'(rgt[r]);
    end
    sum = SUM_W'(row_sum[0]) + (SUM_W'(row_sum[1]) << 1) + SUM_W'(row_sum[2]);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_op  <= q_op;
      a_col <= q_col;
    end
    if (step) begin
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= win[c + 1][r];
        end
      end
      win[2][0] <= top;
      win[2][1] <= rd_middle;
      win[2][2] <= bot;
    end
    if (adv) begin
      b_last   <= a_op.last;
      b_cl     <= a_op.clamp_l;
      b_cr     <= a_op.clamp_r;
      out_pix  <= sum[SUM_W-1:KERNEL_SHIFT];
      out_last <= b_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= q_not_empty;
      b_valid   <= a_valid && a_op.emit;
      out_valid <= b_valid;
    end
  end

endmodule

// File: design/gaussian_blur_3x3_clamp.sv
// Top level of the streaming 3x3 Gaussian blur (kernel 1 2 1 / 2 4 2 / 1 2 1).
// Depends on gb3_pkg, gb3_ifs, gb3_front, gb3_queue, gb3_back.
//
//   channel   role    payload                       handshake
//   pixels    sink    mode, pixel_in                valid / ready
//   blurred   source  blurred_pixel, frame_last     valid / ready
//   cfg       sink    index, data                   valid / ready (always ready)
//
// One item is taken per clock while the step queue has room; the step that
// completes a result passes the queue, line store read, window and kernel sum.
// The first flush of a one-row frame is held on the input for a second step.
// Reset is synchronous and clears the raster position and all valid flags;
// the line stores need no clearing. A stall at the output fills the
// four-entry step queue before the input is held.
module gaussian_blur_3x3_clamp import gb3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  gb3_pix_if.sink   pixels,
  gb3_res_if.source blurred,
  gb3_cfg_if.sink   cfg
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          push;
  gb3_op_t       push_op;
  logic [CW-1:0] push_col;
  logic          q_not_full;
  logic          pop;
  gb3_op_t       head_op;
  logic [CW-1:0] head_col;
  logic          q_not_empty;

  gb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixels),
    .cfg        (cfg),
    .q_not_full (q_not_full),
    .push       (push),
    .op         (push_op),
    .op_col     (push_col)
  );

  gb3_queue #(
    .COL_W (CW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .push_col  (push_col),
    .not_full  (q_not_full),
    .pop       (pop),
    .head_op   (head_op),
    .head_col  (head_col),
    .not_empty (q_not_empty)
  );

  gb3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_op        (head_op),
    .q_col       (head_col),
    .pop         (pop),
    .blurred     (blurred)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the streaming 3x3 Gaussian blur with edge clamping.
// Depends on gb3_pkg, the gb3 channel interfaces and gaussian_blur_3x3_clamp.
module tb import gb3_pkg::*;;

  localparam int unsigned LINE_MAX = DEF_MAX_WIDTH;
  localparam int unsigned ROWS_MAX = DEF_MAX_HEIGHT;
  localparam int IDLE_MAX = 13;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_CAP = 200;
  localparam int RANDOM_ITEMS = 850;
  localparam int unsigned PARTIAL_MAX = 100;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } blur_res_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   mode;
    logic [PIX_W-1:0]       pix;
    logic                   pinned;
    blur_res_t              want;
  } script_row_t;

  localparam int N_ROWS = 33;
  localparam script_row_t DIRECTED [N_ROWS] = '{
    // One-pixel frame after reset: the lone pixel comes back unchanged.
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'hFF, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h00, 1'b0, '{8'h00, 1'b0}}, // push past the end
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h00, 1'b1, '{8'hFF, 1'b1}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h3C, 1'b0, '{8'h00, 1'b0}}, // nothing to drain
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'hFF, 1'b1, '{8'h00, 1'b1}},
    // Zero sizes behave as one.
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'd0, MODE_PUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd0, MODE_PUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'hA5, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h5A, 1'b1, '{8'hA5, 1'b1}},
    // Three by two frame with an early flush that must be dropped.
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'd3, MODE_PUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd2, MODE_PUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h01, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h80, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'hFF, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h7F, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h55, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'hFF, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'hFF, 1'b0, '{8'h00, 1'b0}},
    // A write to an unknown register must not restart the frame.
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'd2, MODE_PUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'd2, MODE_PUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h10, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h20, 1'b0, '{8'h00, 1'b0}},
    '{ROW_WRITE, 4'hF, 13'h1FFF, MODE_PUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h30, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_PUSH,  8'h40, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ROW_ITEM,  '0, '0, MODE_FLUSH, 8'h00, 1'b0, '{8'h00, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  gb3_pix_if pix_ch ();
  gb3_res_if res_ch ();
  gb3_cfg_if cfg_ch ();

  gaussian_blur_3x3_clamp DUT (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .blurred (res_ch),
    .cfg     (cfg_ch)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [FRAME_WIDTH_W-1:0]       width_reg;
  logic [FRAME_HEIGHT_W-1:0]      height_reg;
  logic [PIX_W-1:0]               row_above [LINE_MAX];
  logic [PIX_W-1:0]               row_mid [LINE_MAX];
  int unsigned                    pix_pos;
  int unsigned                    out_pos;
  logic [2:0][2:0][PIX_W-1:0]     taps;  // [column, 0 oldest][row, 0 top]

  blur_res_t awaited_pixels [$];
  bit        pin_on;
  blur_res_t pin_res;
  bit        src_calm;
  bit        sink_calm;
  bit        rush;
  bit        hold_req;
  int        fail_count;
  int        quiet_cycles;
  int        items_sent;

  function automatic int unsigned act_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned act_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > ROWS_MAX) h = ROWS_MAX;
    return h;
  endfunction

  // Moves the window on by one raster position and reports the pixel that
  // it completes, if any.
  function automatic bit blur_step(input bit virt, input logic [PIX_W-1:0] p,
                                   output blur_res_t r);
    int unsigned w, total, j, x, y, cc, s;
    logic [PIX_W-1:0] top, mid, bot;
    logic [2:0][PIX_W-1:0] lcol, mcol, rcol;
    w = act_width();
    total = w * act_height();
    j = pix_pos;
    x = j % w;
    y = j / w;
    top = row_above[x];
    mid = row_mid[x];
    bot = virt ? mid : p;
    r = '0;
    if (y == 1) top = mid;
    taps[0] = taps[1];
    taps[1] = taps[2];
    taps[2] = {bot, mid, top};
    row_above[x] = mid;
    row_mid[x] = bot;
    pix_pos = j + 1;
    if (j < w + 1) return 1'b0;
    cc = (x == 0) ? w - 1 : x - 1;
    lcol = (cc == 0) ? taps[1] : taps[0];
    mcol = taps[1];
    rcol = (cc == w - 1) ? taps[1] : taps[2];
    s = lcol[0] + 2 * mcol[0] + rcol[0]
      + 2 * (lcol[1] + 2 * mcol[1] + rcol[1])
      + lcol[2] + 2 * mcol[2] + rcol[2];
    r.value = PIX_W'(s >> KERNEL_SHIFT);
    r.last = (out_pos + 1 >= total);
    out_pos++;
    if (r.last) begin
      pix_pos = 0;
      out_pos = 0;
    end
    return 1'b1;
  endfunction

  function automatic bit take_item(input logic m, input logic [PIX_W-1:0] p,
                                   output blur_res_t r);
    int unsigned total;
    total = act_width() * act_height();
    r = '0;
    if (m == MODE_PUSH) begin
      if (pix_pos >= total) return 1'b0;
      return blur_step(1'b0, p, r);
    end
    if (pix_pos < total) return 1'b0;
    // A flush runs virtual steps until the next output pixel is complete.
    for (int g = 0; g <= LINE_MAX + 2; g++) begin
      if (blur_step(1'b1, '0, r)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
    if (idx == REG_FRAME_WIDTH) width_reg = d[FRAME_WIDTH_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_reg = d[FRAME_HEIGHT_W-1:0];
    else return;
    pix_pos = 0;
    out_pos = 0;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    blur_res_t want;
    blur_res_t guess;
    bit made;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_pixels.size() == 0) begin
          if (fail_count < REPORT_CAP)
            $error("blurred_pixel %0d arrived with no item expected", res_ch.blurred_pixel);
          fail_count++;
        end else begin
          want = awaited_pixels.pop_front();
          if (res_ch.blurred_pixel !== want.value) begin
            if (fail_count < REPORT_CAP)
              $error("blurred_pixel: expected %0d, got %0d", want.value, res_ch.blurred_pixel);
            fail_count++;
          end
          if (res_ch.frame_last !== want.last) begin
            if (fail_count < REPORT_CAP)
              $error("frame_last: expected %0d, got %0d", want.last, res_ch.frame_last);
            fail_count++;
          end
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        made = take_item(pix_ch.mode, pix_ch.pixel_in, guess);
        if (pin_on) awaited_pixels.push_back(pin_res);
        else if (made) awaited_pixels.push_back(guess);
      end
      if (cfg_ch.valid && cfg_ch.ready) apply_write(cfg_ch.index, cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, calm stretches and one long hold on request.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    sink_calm = 1'b0;
    res_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
      if (hold_req && !held) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        stall = sink_calm ? 0 : $urandom_range(0, IDLE_MAX);
      end
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  task automatic send_item(input logic m, input logic [PIX_W-1:0] p, input bit pinned,
                           input blur_res_t want);
    int gap;
    if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
    gap = (rush || src_calm) ? 0 : $urandom_range(0, IDLE_MAX);
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.mode <= m;
    pix_ch.pixel_in <= p;
    pin_on = pinned;
    pin_res = want;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
  endtask

  // Stops offering items and waits until every expected pixel is out and the
  // pipeline has had time to finish any step that yields no pixel.
  task automatic settle();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sets the frame size, then streams one frame. A partial frame is dropped
  // by the next size write; a pause drains all pending pixels mid-frame.
  task automatic run_frame(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata,
                           input bit partial, input bit pause);
    int unsigned w, total, stop, span, pause_at, drain, k;
    blur_res_t none;
    none = '0;
    settle();
    if ($urandom_range(0, 7) == 0)
      write_reg(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
    if ($urandom_range(0, 1)) begin
      write_reg(REG_FRAME_WIDTH, wdata);
      write_reg(REG_FRAME_HEIGHT, hdata);
    end else begin
      write_reg(REG_FRAME_HEIGHT, hdata);
      write_reg(REG_FRAME_WIDTH, wdata);
    end
    w = act_width();
    total = w * act_height();
    stop = total;
    if (partial && total > 1) begin
      span = (total - 1 < w + 60) ? total - 1 : w + 60;
      if (span > PARTIAL_MAX) span = PARTIAL_MAX;
      stop = $urandom_range(1, span);
    end
    pause_at = pause ? $urandom_range(1, stop) : 0;
    for (k = 0; k < stop; k++) begin
      if ($urandom_range(0, 24) == 0) send_item(MODE_FLUSH, pick_pixel(), 1'b0, none);
      send_item(MODE_PUSH, pick_pixel(), 1'b0, none);
      if (k + 1 == pause_at) settle();
    end
    items_sent += stop;
    if (stop == total) begin
      if ($urandom_range(0, 5) == 0) send_item(MODE_PUSH, pick_pixel(), 1'b0, none);
      drain = (total < w + 1) ? total : w + 1;
      for (k = 0; k < drain; k++) send_item(MODE_FLUSH, pick_pixel(), 1'b0, none);
      items_sent += drain;
      if ($urandom_range(0, 5) == 0) send_item(MODE_FLUSH, pick_pixel(), 1'b0, none);
    end
  endtask

  initial begin
    int unsigned w, h;
    pix_ch.valid = 1'b0;
    pix_ch.mode = MODE_PUSH;
    pix_ch.pixel_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    width_reg = FRAME_WIDTH_W'(1);
    height_reg = FRAME_HEIGHT_W'(1);
    pix_pos = 0;
    out_pos = 0;
    taps = '0;
    foreach (row_above[i]) row_above[i] = '0;
    foreach (row_mid[i]) row_mid[i] = '0;
    items_sent = 0;
    pin_on = 1'b0;
    pin_res = '0;
    src_calm = 1'b0;
    rush = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_item(DIRECTED[i].mode, DIRECTED[i].pix, DIRECTED[i].pinned, DIRECTED[i].want);
      end
    end

    // Size extremes: every data bit set saturates the width to the widest line
    // and the height to the tallest frame. Only the head of such a frame is sent.
    run_frame(13'h1FFF, 13'h1FFF, 1'b1, 1'b0);
    run_frame(13'd1, 13'h1FFF, 1'b1, 1'b0);
    run_frame(13'd1024, 13'd4096, 1'b1, 1'b0);

    // Back-to-back items against a long output hold, so that the input stalls.
    rush = 1'b1;
    hold_req = 1'b1;
    run_frame(13'd4, 13'd12, 1'b0, 1'b1);
    rush = 1'b0;

    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 6);
        end
        6, 7, 8: begin
          w = $urandom_range(9, 40);
          h = $urandom_range(1, 4);
        end
        default: begin
          w = $urandom_range(1, 3);
          h = $urandom_range(20, 60);
        end
      endcase
      run_frame({2'($urandom_range(0, 3)), FRAME_WIDTH_W'(w)}, CFG_DATA_W'(h),
                $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
design/gb3_pkg.sv
design/gb3_ifs.sv
design/gb3_front.sv
design/gb3_queue.sv
design/gb3_back.sv
design/gaussian_blur_3x3_clamp.sv
tb/sv/tb.sv
